### src/wbc_pkg.sv
// Package for the word block cipher in CBC mode.
// Holds the shared types, constants and arithmetic helper functions.
// No dependencies.
`timescale 1ns / 1ps

package wbc_pkg;

   localparam int BLOCK_MAX_DEF  = 64;
   localparam int KEY_MAX_DEF    = 8;
   localparam int FOLD_COUNT_DEF = 8;

   localparam int WORD_W   = 32;
   localparam int CNT_W    = 7;
   localparam int KEY_W    = 4;
   localparam int KIDX_W   = 3;
   localparam int FOLD_W   = 5;
   localparam int TOTAL_W  = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W    = 64;
   localparam int ROUNDS_CAP = 64;
   localparam int STEP_ROT = 7;
   localparam int FOLD_ROT = 7;

   localparam logic [CSR_IDX_W-1:0] REG_DECRYPT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORDS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROUNDS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_01    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_23    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_45    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_67    = 3'd7;

   typedef struct packed {
      logic                   decrypt_mode;
      logic [CNT_W-1:0]       block_words;
      logic [KEY_W-1:0]       key_words;
      logic [CNT_W-1:0]       rounds;
      logic [3:0][CSR_W-1:0]  key_pair;
   } cfg_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              start;
      logic [CNT_W-1:0]  slot;
      logic              last;
   } item_type;

   function automatic logic [WORD_W-1:0] qt(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      a = x + 32'd1;
      b = {x[WORD_W-2:0], 1'b0} + 32'd1;
      return a * b;
   endfunction

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
      int s;
      s = r & 31;
      return (x << s) | (x >> ((32 - s) & 31));
   endfunction

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] maxv);
      if (v == '0) return 7'd1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [CNT_W-1:0] fold_index(input logic [CNT_W-1:0] j2,
                                                   input logic [CNT_W-1:0] n);
      logic [CNT_W:0] twice;
      logic [CNT_W:0] back;
      twice = {j2, 1'b0};
      back  = {(n - j2), 1'b0} - 8'd1;
      if (twice <= {1'b0, n - 7'd1}) return twice[CNT_W-1:0];
      return back[CNT_W-1:0];
   endfunction

endpackage

### src/wbc_ifc.sv
// Valid/ready channel interfaces for the word block cipher.
// Request carries input words, response carries result words; no dependencies.
`timescale 1ns / 1ps

interface wbc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic        message_start;
   modport source (output valid, data_word, message_start, input ready);
   modport sink (input valid, data_word, message_start, output ready);
endinterface

interface wbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_word;
   logic        block_end;
   modport source (output valid, result_word, block_end, input ready);
   modport sink (input valid, result_word, block_end, output ready);
endinterface

### src/word_block_cipher_cbc_top.sv
// Top level of the word block cipher in CBC mode: configuration registers,
// front part, queue and back part. Depends on wbc_pkg, wbc_ifc and all submodules.
// The back part works on one block at a time; each result word stays valid until the response channel is ready.
// Reset is synchronous and active high; it clears control state and the chain valid bits.
`timescale 1ns / 1ps

module word_block_cipher_cbc_top #(
   parameter int BLOCK_MAX  = wbc_pkg::BLOCK_MAX_DEF,
   parameter int KEY_MAX    = wbc_pkg::KEY_MAX_DEF,
   parameter int FOLD_COUNT = wbc_pkg::FOLD_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   wbc_req_if.sink                        req_chan,
   wbc_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_en,
   input  logic [wbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wbc_pkg::CSR_W-1:0]      csr_wdata
);
   import wbc_pkg::*;

   cfg_type  cfg_ff;
   logic     push;
   item_type push_item;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decrypt_mode <= 1'b0;
         cfg_ff.block_words  <= 7'd4;
         cfg_ff.key_words    <= 4'd4;
         cfg_ff.rounds       <= 7'd16;
         cfg_ff.key_pair     <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_DECRYPT:   cfg_ff.decrypt_mode <= csr_wdata[0];
            REG_BLOCK:     cfg_ff.block_words  <= csr_wdata[CNT_W-1:0];
            REG_KEY_WORDS: cfg_ff.key_words    <= csr_wdata[KEY_W-1:0];
            REG_ROUNDS:    cfg_ff.rounds       <= csr_wdata[CNT_W-1:0];
            REG_KEY_01:    cfg_ff.key_pair[0]  <= csr_wdata;
            REG_KEY_23:    cfg_ff.key_pair[1]  <= csr_wdata;
            REG_KEY_45:    cfg_ff.key_pair[2]  <= csr_wdata;
            REG_KEY_67:    cfg_ff.key_pair[3]  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   wbc_front #(.BLOCK_MAX(BLOCK_MAX)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   wbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   wbc_back #(
      .BLOCK_MAX  (BLOCK_MAX),
      .KEY_MAX    (KEY_MAX),
      .FOLD_COUNT (FOLD_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTH
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.block_end) |=> !rsp_chan.valid)
      else $error("result valid right after the last word of a block");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_full && !q_pop) |=> !push || q_pop)
      else $error("queue pushed while full");
`endif
endmodule

### src/wbc_queue.sv
// Two-entry queue between the front and back parts.
// Depends on wbc_pkg for the item type.
`timescale 1ns / 1ps

module wbc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wbc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output wbc_pkg::item_type pop_item
);
   import wbc_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_item  = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

### src/wbc_front.sv
// Front part: accepts input words and tags each with its block slot and end flag.
// Depends on wbc_pkg and the request interface.
`timescale 1ns / 1ps

module wbc_front #(
   parameter int BLOCK_MAX = wbc_pkg::BLOCK_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   wbc_req_if.sink           req_chan,
   input  wbc_pkg::cfg_type  cfg,
   input  logic              q_full,
   output logic              push,
   output wbc_pkg::item_type push_item
);
   import wbc_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] bw;
   logic [CNT_W-1:0] slot;
   logic [CNT_W-1:0] nxt;
   logic             last;

   assign bw   = clamp_count(cfg.block_words, CNT_W'(BLOCK_MAX));
   assign slot = req_chan.message_start ? '0 : count_ff;
   assign nxt  = slot + 7'd1;
   assign last = (nxt >= bw);

   assign req_chan.ready = !q_full;
   assign push = req_chan.valid && !q_full;
   assign push_item.word  = req_chan.data_word;
   assign push_item.start = req_chan.message_start;
   assign push_item.slot  = slot;
   assign push_item.last  = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push) begin
         count_ff <= last ? '0 : nxt;
      end
   end
endmodule

### src/wbc_rem.sv
// Bit-serial remainder unit: a 32-bit word modulo the block size, one bit a cycle.
// Depends on wbc_pkg.
`timescale 1ns / 1ps

module wbc_rem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wbc_pkg::WORD_W-1:0]  dividend,
   input  logic [wbc_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output logic [wbc_pkg::CNT_W-1:0]   rem
);
   import wbc_pkg::*;

   logic [WORD_W-1:0] div_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [4:0]        cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [CNT_W:0]    trial;

   assign trial = {rem_ff, div_ff[WORD_W-1]};
   assign done  = done_ff;
   assign rem   = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= dividend;
         rem_ff <= '0;
      end else if (run_ff) begin
         div_ff <= {div_ff[WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_ff <= CNT_W'(trial - {1'b0, divisor});
         else rem_ff <= trial[CNT_W-1:0];
      end
   end
endmodule

### src/wbc_back.sv
// Back part: loads block words, chains, runs the cipher steps and permutations,
// and emits the result words. Depends on wbc_pkg, wbc_rem and the response interface.
`timescale 1ns / 1ps

module wbc_back #(
   parameter int BLOCK_MAX  = wbc_pkg::BLOCK_MAX_DEF,
   parameter int KEY_MAX    = wbc_pkg::KEY_MAX_DEF,
   parameter int FOLD_COUNT = wbc_pkg::FOLD_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  wbc_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  wbc_pkg::item_type q_item,
   output logic              q_pop,
   wbc_rsp_if.source         rsp_chan
);
   import wbc_pkg::*;

   localparam int AW      = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
   localparam int INV_ROT = (FOLD_ROT * (FOLD_COUNT - 1)) % 32;

   typedef enum logic [4:0] {
      S_IDLE, S_CH_RD, S_CH_WR, S_KM1, S_KM2, S_DCHK, S_ST_K, S_ST_X, S_ST_W,
      S_PA_RD, S_PA_MUL, S_PA_ACC, S_PA_SET, S_FD_MOD, S_FD_WAIT, S_FD_RD, S_FD_WR,
      S_CP_RD, S_CP_WR, S_EM_RD, S_EM_OUT, S_EM_WAIT
   } state_type;

   state_type          state_ff;
   logic               first_ff;
   logic               dec_ff;
   logic [CNT_W-1:0]   bw_ff;
   logic [KEY_W-1:0]   nk_ff;
   logic [CNT_W-1:0]   nr_ff;
   logic [TOTAL_W-1:0] tot_ff;
   logic [TOTAL_W-1:0] i_ff;
   logic [CNT_W-1:0]   w_ff;
   logic [KIDX_W-1:0]  k_ff;
   logic [CNT_W:0]     m_ff;
   logic [CNT_W-1:0]   j_ff;
   logic [CNT_W-1:0]   j2_ff;
   logic [CNT_W-1:0]   fk_ff;
   logic [CNT_W-1:0]   a_ff;
   logic [KEY_W-1:0]   kacc_ff;
   logic [CNT_W-1:0]   r_ff;
   logic [FOLD_W-1:0]  f_ff;
   logic [WORD_W-1:0]  kq_ff;
   logic [WORD_W-1:0]  prod_ff;
   logic [WORD_W-1:0]  acc_ff;
   logic [WORD_W-1:0]  s_ff;
   logic [WORD_W-1:0]  out_word_ff;
   logic               out_end_ff;
   logic               out_valid_ff;

   logic [WORD_W-1:0]  blk_mem_ff [BLOCK_MAX];
   logic [WORD_W-1:0]  scr_mem_ff [BLOCK_MAX];
   logic [WORD_W-1:0]  chn_mem_ff [BLOCK_MAX];
   logic [WORD_W-1:0]  sav_mem_ff [BLOCK_MAX];
   logic [BLOCK_MAX-1:0] chn_vld_ff;
   logic [WORD_W-1:0]  blk_rd_ff;
   logic [WORD_W-1:0]  scr_rd_ff;
   logic [WORD_W-1:0]  chn_rd_ff;
   logic [WORD_W-1:0]  sav_rd_ff;
   logic               chn_vld_rd_ff;

   logic               blk_we;
   logic [AW-1:0]      blk_waddr;
   logic [WORD_W-1:0]  blk_wdata;
   logic [AW-1:0]      blk_raddr;
   logic               scr_we;
   logic [AW-1:0]      scr_waddr;
   logic               chn_we;
   logic               sav_we;
   logic [AW-1:0]      j_addr;

   logic [CNT_W-1:0]   bw_c;
   logic [KEY_W-1:0]   nk_c;
   logic [CNT_W-1:0]   nr_c;
   logic [CNT_W-1:0]   w_prev;
   logic [CNT_W:0]     two_bw;
   logic [WORD_W-1:0]  chain_val;
   logic [WORD_W-1:0]  key_val;
   logic [WORD_W-1:0]  term;
   logic [CNT_W-1:0]   fold_k;
   logic [KEY_W-1:0]   kas;
   logic               j_last;
   logic               perm_due;
   logic               rem_start;
   logic               rem_done;
   logic [CNT_W-1:0]   rem_value;

   wbc_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (s_ff),
      .divisor  (bw_ff),
      .done     (rem_done),
      .rem      (rem_value)
   );

   assign bw_c = clamp_count(cfg.block_words, CNT_W'(BLOCK_MAX));
   assign nk_c = KEY_W'(clamp_count(CNT_W'(cfg.key_words), CNT_W'(KEY_MAX)));
   assign nr_c = (cfg.rounds > CNT_W'(ROUNDS_CAP)) ? CNT_W'(ROUNDS_CAP) : cfg.rounds;

   assign j_addr    = j_ff[AW-1:0];
   assign j_last    = (j_ff == bw_ff - 7'd1);
   assign w_prev    = (w_ff == '0) ? bw_ff - 7'd1 : w_ff - 7'd1;
   assign two_bw    = {bw_ff, 1'b0};
   assign chain_val = (!first_ff && chn_vld_rd_ff) ? chn_rd_ff : '0;
   assign key_val   = k_ff[0] ? cfg.key_pair[k_ff[2:1]][63:32]
                              : cfg.key_pair[k_ff[2:1]][31:0];
   assign term      = rotl(prod_ff, STEP_ROT);
   assign fold_k    = fold_index(j2_ff, bw_ff);
   assign kas       = kacc_ff + a_ff[KEY_W-1:0];
   assign perm_due  = (i_ff != '0) && (m_ff == '0);
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rem_start = (state_ff == S_FD_MOD);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.result_word = out_word_ff;
   assign rsp_chan.block_end   = out_end_ff;

   always_comb begin
      blk_we    = 1'b0;
      blk_waddr = j_addr;
      blk_wdata = blk_rd_ff;
      blk_raddr = j_addr;
      scr_we    = 1'b0;
      scr_waddr = j_addr;
      chn_we    = 1'b0;
      sav_we    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            blk_we    = q_pop;
            blk_waddr = q_item.slot[AW-1:0];
            blk_wdata = q_item.word;
         end
         S_CH_WR: begin
            blk_we    = !dec_ff;
            blk_wdata = blk_rd_ff ^ chain_val;
            sav_we    = dec_ff;
         end
         S_ST_K: blk_raddr = w_prev[AW-1:0];
         S_ST_X: blk_raddr = w_ff[AW-1:0];
         S_ST_W: begin
            blk_we    = 1'b1;
            blk_waddr = w_ff[AW-1:0];
            blk_wdata = dec_ff ? blk_rd_ff - term : blk_rd_ff + term;
         end
         S_FD_RD: blk_raddr = dec_ff ? fold_k[AW-1:0] : j_addr;
         S_FD_WR: begin
            scr_we    = 1'b1;
            scr_waddr = dec_ff ? j_addr : fk_ff[AW-1:0];
         end
         S_CP_WR: begin
            blk_we    = 1'b1;
            blk_wdata = scr_rd_ff;
         end
         S_EM_OUT: chn_we = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (blk_we) blk_mem_ff[blk_waddr] <= blk_wdata;
      blk_rd_ff <= blk_mem_ff[blk_raddr];
   end

   always_ff @(posedge clock) begin
      if (scr_we) scr_mem_ff[scr_waddr] <= blk_rd_ff;
      scr_rd_ff <= scr_mem_ff[j_addr];
   end

   always_ff @(posedge clock) begin
      if (sav_we) sav_mem_ff[j_addr] <= blk_rd_ff;
      sav_rd_ff <= sav_mem_ff[j_addr];
   end

   always_ff @(posedge clock) begin
      if (chn_we) chn_mem_ff[j_addr] <= dec_ff ? sav_rd_ff : blk_rd_ff;
      chn_rd_ff <= chn_mem_ff[j_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chn_vld_ff    <= '0;
         chn_vld_rd_ff <= 1'b0;
      end else begin
         if (chn_we) chn_vld_ff[j_addr] <= 1'b1;
         chn_vld_rd_ff <= chn_vld_ff[j_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  if (q_item.start) first_ff <= 1'b1;
                  if (q_item.last) begin
                     dec_ff   <= cfg.decrypt_mode;
                     bw_ff    <= bw_c;
                     nk_ff    <= nk_c;
                     nr_ff    <= nr_c;
                     tot_ff   <= TOTAL_W'(bw_c) * TOTAL_W'(nr_c);
                     j_ff     <= '0;
                     state_ff <= S_CH_RD;
                  end
               end
            end
            S_CH_RD: state_ff <= S_CH_WR;
            S_CH_WR: begin
               j_ff <= j_ff + 7'd1;
               if (!j_last) begin
                  state_ff <= S_CH_RD;
               end else if (tot_ff == '0) begin
                  j_ff     <= '0;
                  state_ff <= S_EM_RD;
               end else if (dec_ff) begin
                  a_ff     <= bw_ff;
                  state_ff <= S_KM1;
               end else begin
                  i_ff     <= '0;
                  w_ff     <= '0;
                  k_ff     <= '0;
                  m_ff     <= '0;
                  state_ff <= S_ST_K;
               end
            end
            S_KM1: begin
               if (a_ff >= CNT_W'(nk_ff)) begin
                  a_ff <= a_ff - CNT_W'(nk_ff);
               end else begin
                  kacc_ff  <= '0;
                  r_ff     <= '0;
                  state_ff <= S_KM2;
               end
            end
            S_KM2: begin
               if (r_ff == nr_ff) begin
                  k_ff     <= (kacc_ff == '0) ? KIDX_W'(nk_ff - 4'd1)
                                              : KIDX_W'(kacc_ff - 4'd1);
                  i_ff     <= tot_ff - 13'd1;
                  w_ff     <= bw_ff - 7'd1;
                  m_ff     <= nr_ff[0] ? {1'b0, bw_ff - 7'd1} : two_bw - 8'd1;
                  state_ff <= S_DCHK;
               end else begin
                  kacc_ff <= (kas >= nk_ff) ? kas - nk_ff : kas;
                  r_ff    <= r_ff + 7'd1;
               end
            end
            S_DCHK: begin
               if (perm_due) begin
                  j_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= S_PA_RD;
               end else begin
                  state_ff <= S_ST_K;
               end
            end
            S_ST_K: begin
               kq_ff    <= qt(key_val);
               state_ff <= S_ST_X;
            end
            S_ST_X: begin
               prod_ff  <= qt(blk_rd_ff ^ kq_ff);
               state_ff <= S_ST_W;
            end
            S_ST_W: begin
               if (dec_ff) begin
                  if (i_ff == '0) begin
                     j_ff     <= '0;
                     state_ff <= S_EM_RD;
                  end else begin
                     i_ff     <= i_ff - 13'd1;
                     w_ff     <= w_prev;
                     k_ff     <= (k_ff == '0) ? KIDX_W'(nk_ff - 4'd1) : k_ff - 3'd1;
                     m_ff     <= (m_ff == '0) ? two_bw - 8'd1 : m_ff - 8'd1;
                     state_ff <= S_DCHK;
                  end
               end else begin
                  i_ff <= i_ff + 13'd1;
                  w_ff <= (w_ff == bw_ff - 7'd1) ? '0 : w_ff + 7'd1;
                  k_ff <= (KEY_W'(k_ff) == nk_ff - 4'd1) ? '0 : k_ff + 3'd1;
                  m_ff <= (m_ff == two_bw - 8'd1) ? '0 : m_ff + 8'd1;
                  if (perm_due) begin
                     j_ff     <= '0;
                     acc_ff   <= '0;
                     state_ff <= S_PA_RD;
                  end else if (i_ff + 13'd1 == tot_ff) begin
                     j_ff     <= '0;
                     state_ff <= S_EM_RD;
                  end else begin
                     state_ff <= S_ST_K;
                  end
               end
            end
            S_PA_RD: state_ff <= S_PA_MUL;
            S_PA_MUL: begin
               prod_ff  <= qt(blk_rd_ff);
               state_ff <= S_PA_ACC;
            end
            S_PA_ACC: begin
               acc_ff   <= acc_ff ^ prod_ff;
               j_ff     <= j_ff + 7'd1;
               state_ff <= j_last ? S_PA_SET : S_PA_RD;
            end
            S_PA_SET: begin
               s_ff     <= dec_ff ? rotl(acc_ff, INV_ROT) : acc_ff;
               f_ff     <= '0;
               state_ff <= S_FD_MOD;
            end
            S_FD_MOD: state_ff <= S_FD_WAIT;
            S_FD_WAIT: begin
               if (rem_done) begin
                  j2_ff    <= rem_value;
                  j_ff     <= '0;
                  state_ff <= S_FD_RD;
               end
            end
            S_FD_RD: begin
               fk_ff    <= fold_k;
               state_ff <= S_FD_WR;
            end
            S_FD_WR: begin
               j_ff  <= j_ff + 7'd1;
               j2_ff <= (j2_ff == bw_ff - 7'd1) ? '0 : j2_ff + 7'd1;
               if (j_last) begin
                  j_ff     <= '0;
                  state_ff <= S_CP_RD;
               end else begin
                  state_ff <= S_FD_RD;
               end
            end
            S_CP_RD: state_ff <= S_CP_WR;
            S_CP_WR: begin
               j_ff <= j_ff + 7'd1;
               if (!j_last) begin
                  state_ff <= S_CP_RD;
               end else begin
                  f_ff <= f_ff + 5'd1;
                  s_ff <= dec_ff ? rotl(s_ff, 32 - FOLD_ROT) : rotl(s_ff, FOLD_ROT);
                  if (f_ff != FOLD_W'(FOLD_COUNT - 1)) begin
                     state_ff <= S_FD_MOD;
                  end else if (!dec_ff && i_ff == tot_ff) begin
                     j_ff     <= '0;
                     state_ff <= S_EM_RD;
                  end else begin
                     state_ff <= S_ST_K;
                  end
               end
            end
            S_EM_RD: state_ff <= S_EM_OUT;
            S_EM_OUT: begin
               out_word_ff  <= dec_ff ? blk_rd_ff ^ chain_val : blk_rd_ff;
               out_end_ff   <= j_last;
               out_valid_ff <= 1'b1;
               state_ff     <= S_EM_WAIT;
            end
            S_EM_WAIT: begin
               if (rsp_chan.ready) begin
                  out_valid_ff <= 1'b0;
                  if (out_end_ff) begin
                     first_ff <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     j_ff     <= j_ff + 7'd1;
                     state_ff <= S_EM_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### tb/word_block_cipher_cbc_top_test.sv
// Self-checking testbench for the CBC word block cipher top level.
// Predicts every result word in its own model and compares each response transfer;
// depends on wbc_pkg, wbc_ifc and the RTL of word_block_cipher_cbc_top.
`timescale 1ns / 1ps

module word_block_cipher_cbc_top_test;
   import wbc_pkg::*;

   localparam int IDLE_LIMIT = 400000;
   localparam int ITEM_GOAL  = 380;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } cipher_word_type;

   logic clock;
   logic reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   wbc_req_if req_chan();
   wbc_rsp_if rsp_chan();

   word_block_cipher_cbc_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Predictor state.
   logic        mode_dec;
   logic [6:0]  size_reg;
   logic [3:0]  keys_reg;
   logic [6:0]  rounds_reg;
   logic [63:0] key_reg [4];
   logic [31:0] blk [64];
   logic [31:0] tmp [64];
   logic [31:0] chn [64];
   int          fill;
   bit          fresh_msg;

   cipher_word_type cipher_words_due [$];
   int  error_count;
   int  items_sent;
   int  idle_cycles;
   bit  idling_on;
   int  stall_left;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [31:0] quad_mix(input logic [31:0] x);
      logic [31:0] a;
      logic [31:0] b;
      a = x + 32'd1;
      b = (x << 1) + 32'd1;
      return a * b;
   endfunction

   function automatic logic [31:0] rot_left(input logic [31:0] x, input int r);
      int s;
      s = r & 31;
      if (s == 0) return x;
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic int fold_pos(input int i, input int n);
      if (2 * i <= n - 1) return 2 * i;
      return 2 * (n - i) - 1;
   endfunction

   function automatic logic [31:0] key_at(input int i);
      logic [63:0] pair;
      pair = key_reg[(i >> 1) & 3];
      return (i & 1) ? pair[63:32] : pair[31:0];
   endfunction

   function automatic logic [31:0] step_term(input int i, input int bw, input int nk);
      int w;
      int p;
      w = i % bw;
      p = (w > 0) ? w - 1 : bw - 1;
      return rot_left(quad_mix(blk[p] ^ quad_mix(key_at(i % nk))), 7);
   endfunction

   function automatic void shuffle(input int bw, input bit inv);
      logic [31:0] sums [8];
      logic [31:0] acc;
      logic [31:0] s;
      longint      j2;
      int          k;
      acc = '0;
      for (int j = 0; j < bw; j++) acc ^= quad_mix(blk[j]);
      for (int f = 0; f < 8; f++) begin
         sums[f] = acc;
         acc = rot_left(acc, 7);
      end
      for (int f = 0; f < 8; f++) begin
         s = inv ? sums[7 - f] : sums[f];
         for (int j = 0; j < bw; j++) begin
            j2 = (longint'(j) + longint'({32'd0, s})) % bw;
            k = fold_pos(int'(j2), bw);
            if (k >= bw) k = 0;
            if (inv) tmp[j] = blk[k];
            else tmp[k] = blk[j];
         end
         for (int j = 0; j < bw; j++) blk[j] = tmp[j];
      end
   endfunction

   task automatic take_word(input logic [31:0] w, input logic st);
      int bw;
      int nk;
      int nr;
      int total;
      logic [31:0] saved [64];
      logic [31:0] res;
      cipher_word_type cw;
      bw = (size_reg == 0) ? 1 : (size_reg > 64) ? 64 : size_reg;
      nk = (keys_reg == 0) ? 1 : (keys_reg > 8) ? 8 : keys_reg;
      nr = (rounds_reg > 64) ? 64 : rounds_reg;
      total = nr * bw;
      if (st) begin
         fill = 0;
         fresh_msg = 1'b1;
      end
      if (fill >= 64) fill = 0;
      blk[fill] = w;
      fill++;
      if (fill < bw) return;
      if (!mode_dec) begin
         for (int i = 0; i < bw; i++) blk[i] ^= fresh_msg ? 32'd0 : chn[i];
         for (int i = 0; i < total; i++) begin
            blk[i % bw] += step_term(i, bw, nk);
            if (i > 0 && (i % (2 * bw)) == 0) shuffle(bw, 1'b0);
         end
      end else begin
         for (int i = 0; i < bw; i++) saved[i] = blk[i];
         for (int i = total - 1; i >= 0; i--) begin
            if (i > 0 && (i % (2 * bw)) == 0) shuffle(bw, 1'b1);
            blk[i % bw] -= step_term(i, bw, nk);
         end
      end
      for (int i = 0; i < bw; i++) begin
         if (!mode_dec) begin
            res = blk[i];
            chn[i] = blk[i];
         end else begin
            res = blk[i] ^ (fresh_msg ? 32'd0 : chn[i]);
            chn[i] = saved[i];
         end
         cw.word = res;
         cw.last = (i == bw - 1);
         cipher_words_due.push_back(cw);
      end
      fresh_msg = 1'b0;
      fill = 0;
   endtask

   // Sends one word; returns at the edge of its transfer, maybe after a gap.
   task automatic send_word(input logic [31:0] w, input logic st);
      bit took;
      req_chan.valid         <= 1'b1;
      req_chan.data_word     <= w;
      req_chan.message_start <= st;
      do begin
         @(negedge clock);
         took = req_chan.ready;
         @(posedge clock);
      end while (!took);
      take_word(w, st);
      items_sent++;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (cipher_words_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_DECRYPT:   mode_dec   = val[0];
         REG_BLOCK:     size_reg   = val[6:0];
         REG_KEY_WORDS: keys_reg   = val[3:0];
         REG_ROUNDS:    rounds_reg = val[6:0];
         REG_KEY_01:    key_reg[0] = val;
         REG_KEY_23:    key_reg[1] = val;
         REG_KEY_45:    key_reg[2] = val;
         default:       key_reg[3] = val;
      endcase
   endtask

   task automatic set_shape(input logic dec, input int bw, input int kw, input int nr);
      write_reg(REG_DECRYPT, {63'd0, dec});
      write_reg(REG_BLOCK, 64'(bw));
      write_reg(REG_KEY_WORDS, 64'(kw));
      write_reg(REG_ROUNDS, 64'(nr));
   endtask

   task automatic test_default_chain();
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h8000_0001, 1'b0);
      send_word($urandom(), 1'b0);
      for (int i = 0; i < 4; i++) send_word($urandom(), 1'b0);
      drain();
   endtask

   task automatic test_register_extremes();
      set_shape(1'b0, 0, 0, 0);
      send_word(32'hFFFF_FFFF, 1'b1);
      drain();
      write_reg(REG_KEY_01, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_KEY_23, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_KEY_45, 64'h0123_4567_89AB_CDEF);
      write_reg(REG_KEY_67, 64'hFEDC_BA98_7654_3210);
      set_shape(1'b1, 2, 15, 127);
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      drain();
   endtask

   task automatic test_restart_mid_block();
      set_shape(1'b0, 4, 3, 3);
      send_word($urandom(), 1'b1);
      send_word($urandom(), 1'b0);
      for (int i = 0; i < 4; i++) send_word($urandom(), i == 0);
      drain();
   endtask

   task automatic test_resize_mid_block();
      set_shape(1'b1, 5, 2, 2);
      for (int i = 0; i < 3; i++) send_word($urandom(), i == 0);
      drain();
      write_reg(REG_BLOCK, 64'd2);
      send_word($urandom(), 1'b0);
      drain();
   endtask

   task automatic test_widest_blocks();
      set_shape(1'b0, 100, 8, 2);
      for (int i = 0; i < 64; i++) send_word($urandom(), i == 0);
      drain();
      set_shape(1'b1, 64, 8, 64);
      for (int i = 0; i < 64; i++) send_word($urandom(), i == 0);
      drain();
   endtask

   task automatic test_random_traffic();
      int bw;
      int blocks;
      while (items_sent < ITEM_GOAL) begin
         if (items_sent > ITEM_GOAL - 50) idling_on = 1'b0;
         bw = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 20);
         for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 1))
               write_reg(CSR_IDX_W'(int'(REG_KEY_01) + k), {$urandom(), $urandom()});
         set_shape(1'($urandom_range(0, 1)), bw, $urandom_range(0, 15),
                   ($urandom_range(0, 5) != 0) ? $urandom_range(0, 8) : $urandom_range(9, 127));
         blocks = $urandom_range(1, 4);
         for (int b = 0; b < blocks; b++)
            for (int i = 0; i < bw; i++)
               send_word($urandom(), (b == 0 && i == 0) || $urandom_range(0, 19) == 0);
         drain();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(1, 10) - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      cipher_word_type cw;
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (cipher_words_due.size() == 0) begin
            $error("unexpected result word %h", rsp_chan.result_word);
            error_count++;
         end else begin
            cw = cipher_words_due.pop_front();
            if (rsp_chan.result_word !== cw.word) begin
               $error("result_word expected %h actual %h", cw.word, rsp_chan.result_word);
               error_count++;
            end
            if (rsp_chan.block_end !== cw.last) begin
               $error("block_end expected %b actual %b", cw.last, rsp_chan.block_end);
               error_count++;
            end
         end
      end
      if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("word_block_cipher_cbc_top_test: errors");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.data_word     <= '0;
      req_chan.message_start <= 1'b0;
      mode_dec   = 1'b0;
      size_reg   = 7'd4;
      keys_reg   = 4'd4;
      rounds_reg = 7'd16;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      for (int i = 0; i < 64; i++) chn[i] = '0;
      fill        = 0;
      fresh_msg   = 1'b1;
      error_count = 0;
      items_sent  = 0;
      idle_cycles = 0;
      idling_on   = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_chain();
      test_register_extremes();
      test_restart_mid_block();
      test_resize_mid_block();
      test_widest_blocks();
      test_random_traffic();
      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("word_block_cipher_cbc_top_test: clean");
      else
         $display("word_block_cipher_cbc_top_test: errors");
      $finish;
   end

endmodule

### filelist.f
src/wbc_pkg.sv
src/wbc_ifc.sv
src/wbc_queue.sv
src/wbc_front.sv
src/wbc_rem.sv
src/wbc_back.sv
src/word_block_cipher_cbc_top.sv
tb/word_block_cipher_cbc_top_test.sv
